// ===== rtl/cec_pkg.sv =====
// ----------------------------------------------------------------------------
// cec_pkg: shared widths and types of the disc collision pipeline
// fixed-point widths used by the stages and the sideband that rides the divider
// ----------------------------------------------------------------------------
package cec_pkg;

	localparam int VW    = 24;          // velocity and position fields
	localparam int LANES = 4;           // correction terms per item
	localparam int QB    = 31;          // quotient bits below the clamp
	localparam int DW    = 68;          // divisor: twice mass sum times dsq
	localparam int NW    = 93;          // dividend: twice numerator plus den
	localparam int CW    = DW + QB;     // compare width in a divider stage

	typedef struct packed {
		logic signed [VW-1:0] v1x;
		logic signed [VW-1:0] v1y;
		logic signed [VW-1:0] v2x;
		logic signed [VW-1:0] v2y;
		logic [LANES-1:0]     neg;      // sign of each correction term
		logic [LANES-1:0]     big;      // quotient beyond the clamp point
		logic                 touch;
		logic                 coin;
		logic                 nocorr;   // mass sum zero
	} side_t;

endpackage

// ===== rtl/cec_divider.sv =====
// ----------------------------------------------------------------------------
// cec_divider: pipelined restoring divider, four lanes on one divisor
// one quotient bit per stage, sideband carried alongside each item
// ----------------------------------------------------------------------------
module cec_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [cec_pkg::NW-1:0] num [cec_pkg::LANES],
	input  logic [cec_pkg::DW-1:0] den,
	input  cec_pkg::side_t       side_in,
	output logic                 out_valid,
	output logic [cec_pkg::QB-1:0] quo [cec_pkg::LANES],
	output cec_pkg::side_t       side_out
);
	import cec_pkg::*;

	logic           vld_r [QB];
	logic [NW-1:0]  rem_r [QB][LANES];
	logic [QB-1:0]  q_r   [QB][LANES];
	logic [DW-1:0]  d_r   [QB];
	side_t          sd_r  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic          vld_in;
		logic [NW-1:0] rem_in [LANES];
		logic [QB-1:0] q_in   [LANES];
		logic [DW-1:0] d_in;
		side_t         sd_in;
		logic [CW:0]   trial  [LANES];
		logic [NW-1:0] rem_nx [LANES];
		logic [QB-1:0] q_nx   [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				vld_in = in_valid;
				d_in   = den;
				sd_in  = side_in;
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = num[l];
					q_in[l]   = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				vld_in = vld_r[k-1];
				d_in   = d_r[k-1];
				sd_in  = sd_r[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = rem_r[k-1][l];
					q_in[l]   = q_r[k-1][l];
				end
			end
		end

		// trial subtract of the divisor aligned to this bit
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {{(CW+1-NW){1'b0}}, rem_in[l]}
					- ({{(CW+1-DW){1'b0}}, d_in} << B);
				if (!trial[l][CW]) begin
					rem_nx[l] = trial[l][NW-1:0];
					q_nx[l]   = q_in[l] | (QB'(1) << B);
				end else begin
					rem_nx[l] = rem_in[l];
					q_nx[l]   = q_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k] <= 1'b0;
			end else if (en) begin
				vld_r[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_r[k]  <= d_in;
				sd_r[k] <= sd_in;
				for (int l = 0; l < LANES; l++) begin
					rem_r[k][l] <= rem_nx[l];
					q_r[k][l]   <= q_nx[l];
				end
			end
		end
	end

	assign out_valid = vld_r[QB-1];
	assign side_out  = sd_r[QB-1];
	always_comb begin
		for (int l = 0; l < LANES; l++) quo[l] = q_r[QB-1][l];
	end

	// no clamp means the dividend fits below divisor times two to the qb
	a_fit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && en && !side_in.big[0] && den != '0
		|-> {{(CW-NW){1'b0}}, num[0]} < {den, {QB{1'b0}}})
		else $error("dividend beyond quotient range without clamp");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_r[QB-1] && !sd_r[QB-1].big[3] && d_r[QB-1] != '0
		|-> {{(CW-NW){1'b0}}, rem_r[QB-1][3]} < {{(CW-DW){1'b0}}, d_r[QB-1]})
		else $error("final remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_valid) && $stable(q_r[QB-1][0]))
		else $error("divider moved while stalled");

endmodule

// ===== rtl/circle_elastic_collision.sv =====
// ----------------------------------------------------------------------------
// circle_elastic_collision: contact test and 2d elastic velocity resolve
// path: an accepted item passes stages s1 to s9, the quotient stages, then the output register
// throughput: one item per cycle while the output is not stalled, set by the 31-stage quotient pipeline
// a stall at the output freezes every stage, nothing is dropped or repeated
// reset: arst_n clears all stage valid bits, pipeline comes up empty
// ----------------------------------------------------------------------------
module circle_elastic_collision (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic signed [cec_pkg::VW-1:0] first_pos_x,
	input  logic signed [cec_pkg::VW-1:0] first_pos_y,
	input  logic signed [cec_pkg::VW-1:0] second_pos_x,
	input  logic signed [cec_pkg::VW-1:0] second_pos_y,
	input  logic signed [cec_pkg::VW-1:0] first_vel_x,
	input  logic signed [cec_pkg::VW-1:0] first_vel_y,
	input  logic signed [cec_pkg::VW-1:0] second_vel_x,
	input  logic signed [cec_pkg::VW-1:0] second_vel_y,
	input  logic [15:0]                 first_mass,
	input  logic [15:0]                 second_mass,
	input  logic [15:0]                 first_radius,
	input  logic [15:0]                 second_radius,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        touching,
	output logic                        centres_coincide,
	output logic signed [cec_pkg::VW-1:0] new_first_vel_x,
	output logic signed [cec_pkg::VW-1:0] new_first_vel_y,
	output logic signed [cec_pkg::VW-1:0] new_second_vel_x,
	output logic signed [cec_pkg::VW-1:0] new_second_vel_y
);
	import cec_pkg::*;

	localparam int HW   = 25;          // half width of split multiplies
	localparam int TW   = QB + 1;      // signed correction term
	localparam int SUMW = TW + 2;      // velocity plus term before clamp

	// one enable for the whole pipe: move when the output slot is free
	logic en;
	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	side_t side_s8, side_s9;
	// sideband entering s3, s4 and s9 with the fields filled there
	side_t side_to_s3, side_to_s4, side_to_s9;

	// s1: differences, radius sum, mass terms
	logic signed [HW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [20:0] rs_s1;
	logic [16:0] msum_s1, tm1_s1, tm2_s1;
	// s2: squares and dot partials
	logic [49:0] dx2_s2, dy2_s2;
	logic signed [49:0] px_s2, py_s2;
	logic [41:0] rs2_s2;
	logic signed [HW-1:0] dx_s2, dy_s2;
	logic [16:0] msum_s2, tm1_s2, tm2_s2;
	// s3: squared distance, dot product, contact flags
	logic [49:0] dsq_s3;
	logic signed [49:0] dot_s3;
	logic signed [HW-1:0] dx_s3, dy_s3;
	logic [16:0] msum_s3, tm1_s3, tm2_s3;
	// s4: magnitudes, denominator partials
	logic [49:0] dm_s4;
	logic [HW-1:0] cmx_s4, cmy_s4;
	logic [41:0] dlo_s4, dhi_s4;
	logic [16:0] tm1_s4, tm2_s4;
	// s5: numerator partials, denominator
	logic [49:0] pxl_s5, pxh_s5, pyl_s5, pyh_s5;
	logic [66:0] den_s5, den_s6, den_s7, den_s8;
	logic [16:0] tm1_s5, tm2_s5, tm1_s6, tm2_s6;
	// s6: dot times component
	logic [74:0] ax_s6, ay_s6;
	// s7: chunk products with twice the mass
	logic [41:0] pr_s7 [LANES][3];
	// s8: full numerators
	logic [91:0] n_s8 [LANES];
	// s9: divider operands
	logic [NW-1:0] num_s9 [LANES];
	logic [DW-1:0] dv_s9;

	always_comb begin
		// exact contact compare and coinciding centres
		side_to_s3       = side_s2;
		side_to_s3.touch = (dx2_s2 + dy2_s2) <= {8'b0, rs2_s2};
		side_to_s3.coin  = (dx2_s2 + dy2_s2) == '0;
		// lanes: x with m2, y with m2, x with m1, y with m1
		side_to_s4     = side_s3;
		side_to_s4.neg = {dot_s3[49] ^ dy_s3[HW-1], dot_s3[49] ^ dx_s3[HW-1],
			dot_s3[49] ^ dy_s3[HW-1], dot_s3[49] ^ dx_s3[HW-1]};
		// quotient at or past two to the qb gets clamped
		side_to_s9 = side_s8;
		for (int l = 0; l < LANES; l++) begin
			side_to_s9.big[l] = {6'b0, ({n_s8[l], 1'b0} + {26'b0, den_s8})}
				>= {den_s8, 1'b0, {QB{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			dx_s1   <= HW'(second_pos_x) - HW'(first_pos_x);
			dy_s1   <= HW'(second_pos_y) - HW'(first_pos_y);
			dvx_s1  <= HW'(second_vel_x) - HW'(first_vel_x);
			dvy_s1  <= HW'(second_vel_y) - HW'(first_vel_y);
			rs_s1   <= {({1'b0, first_radius} + {1'b0, second_radius}), 4'b0000};
			msum_s1 <= {1'b0, first_mass} + {1'b0, second_mass};
			tm1_s1  <= {first_mass, 1'b0};
			tm2_s1  <= {second_mass, 1'b0};
			side_s1.v1x    <= first_vel_x;
			side_s1.v1y    <= first_vel_y;
			side_s1.v2x    <= second_vel_x;
			side_s1.v2y    <= second_vel_y;
			side_s1.neg    <= '0;
			side_s1.big    <= '0;
			side_s1.touch  <= 1'b0;
			side_s1.coin   <= 1'b0;
			side_s1.nocorr <= (first_mass == '0) && (second_mass == '0);

			// s2
			dx2_s2  <= 50'(dx_s1 * dx_s1);
			dy2_s2  <= 50'(dy_s1 * dy_s1);
			px_s2   <= dvx_s1 * dx_s1;
			py_s2   <= dvy_s1 * dy_s1;
			rs2_s2  <= rs_s1 * rs_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			msum_s2 <= msum_s1;
			tm1_s2  <= tm1_s1;
			tm2_s2  <= tm2_s1;
			side_s2 <= side_s1;

			// s3: exact contact compare
			dsq_s3  <= dx2_s2 + dy2_s2;
			dot_s3  <= px_s2 + py_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			msum_s3 <= msum_s2;
			tm1_s3  <= tm1_s2;
			tm2_s3  <= tm2_s2;
			side_s3 <= side_to_s3;

			// s4: magnitudes, term signs, mass sum times dsq split in halves
			dm_s4   <= dot_s3[49] ? $unsigned(-dot_s3) : $unsigned(dot_s3);
			cmx_s4  <= dx_s3[HW-1] ? $unsigned(-dx_s3) : $unsigned(dx_s3);
			cmy_s4  <= dy_s3[HW-1] ? $unsigned(-dy_s3) : $unsigned(dy_s3);
			dlo_s4  <= msum_s3 * dsq_s3[HW-1:0];
			dhi_s4  <= msum_s3 * dsq_s3[2*HW-1:HW];
			tm1_s4  <= tm1_s3;
			tm2_s4  <= tm2_s3;
			side_s4 <= side_to_s4;

			// s5
			pxl_s5  <= dm_s4[HW-1:0] * cmx_s4;
			pxh_s5  <= dm_s4[2*HW-1:HW] * cmx_s4;
			pyl_s5  <= dm_s4[HW-1:0] * cmy_s4;
			pyh_s5  <= dm_s4[2*HW-1:HW] * cmy_s4;
			den_s5  <= {25'b0, dlo_s4} + {dhi_s4, 25'b0};
			tm1_s5  <= tm1_s4;
			tm2_s5  <= tm2_s4;
			side_s5 <= side_s4;

			// s6
			ax_s6   <= {25'b0, pxl_s5} + {pxh_s5, 25'b0};
			ay_s6   <= {25'b0, pyl_s5} + {pyh_s5, 25'b0};
			den_s6  <= den_s5;
			tm1_s6  <= tm1_s5;
			tm2_s6  <= tm2_s5;
			side_s6 <= side_s5;

			// s7: three chunks per lane
			for (int c = 0; c < 3; c++) begin
				pr_s7[0][c] <= ax_s6[c*HW +: HW] * tm2_s6;
				pr_s7[1][c] <= ay_s6[c*HW +: HW] * tm2_s6;
				pr_s7[2][c] <= ax_s6[c*HW +: HW] * tm1_s6;
				pr_s7[3][c] <= ay_s6[c*HW +: HW] * tm1_s6;
			end
			den_s7  <= den_s6;
			side_s7 <= side_s6;

			// s8
			for (int l = 0; l < LANES; l++) begin
				n_s8[l] <= {50'b0, pr_s7[l][0]} + {25'b0, pr_s7[l][1], 25'b0}
					+ {pr_s7[l][2], 50'b0};
			end
			den_s8  <= den_s7;
			side_s8 <= side_s7;

			// s9: round to nearest by dividing 2n+den by 2den
			dv_s9   <= {den_s8, 1'b0};
			side_s9 <= side_to_s9;
			for (int l = 0; l < LANES; l++) begin
				num_s9[l] <= {n_s8[l], 1'b0} + {26'b0, den_s8};
			end
		end
	end

	// quotient pipeline
	logic          dv_valid;
	logic [QB-1:0] quo [LANES];
	side_t         side_d;

	cec_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.num       (num_s9),
		.den       (dv_s9),
		.side_in   (side_s9),
		.out_valid (dv_valid),
		.quo       (quo),
		.side_out  (side_d)
	);

	function automatic logic signed [VW-1:0] sat_vel(input logic signed [SUMW-1:0] s);
		logic signed [SUMW-1:0] hi, lo;
		hi = (SUMW'(1) <<< (VW-1)) - SUMW'(1);
		lo = -(SUMW'(1) <<< (VW-1));
		if (s > hi) return hi[VW-1:0];
		if (s < lo) return lo[VW-1:0];
		return s[VW-1:0];
	endfunction

	// apply terms: first disc gains lanes 0/1, second loses lanes 2/3
	logic signed [TW-1:0]   term [LANES];
	logic [QB-1:0]          mag  [LANES];
	logic signed [SUMW-1:0] s1x, s1y, s2x, s2y;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag[l]  = side_d.big[l] ? (QB'(1) << (QB-1)) : quo[l];
			term[l] = side_d.neg[l] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
			if (side_d.nocorr) term[l] = '0;
		end
		s1x = SUMW'(side_d.v1x) + SUMW'(term[0]);
		s1y = SUMW'(side_d.v1y) + SUMW'(term[1]);
		s2x = SUMW'(side_d.v2x) - SUMW'(term[2]);
		s2y = SUMW'(side_d.v2y) - SUMW'(term[3]);
	end

	logic                 out_valid_q;
	logic                 touch_q, coin_q;
	logic signed [VW-1:0] nv1x_q, nv1y_q, nv2x_q, nv2y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			touch_q <= side_d.touch;
			coin_q  <= side_d.coin;
			// coinciding centres: no normal, all velocities zero
			nv1x_q  <= side_d.coin ? '0 : sat_vel(s1x);
			nv1y_q  <= side_d.coin ? '0 : sat_vel(s1y);
			nv2x_q  <= side_d.coin ? '0 : sat_vel(s2x);
			nv2y_q  <= side_d.coin ? '0 : sat_vel(s2y);
		end
	end

	assign result_valid     = out_valid_q;
	assign touching         = touch_q;
	assign centres_coincide = coin_q;
	assign new_first_vel_x  = nv1x_q;
	assign new_first_vel_y  = nv1y_q;
	assign new_second_vel_x = nv2x_q;
	assign new_second_vel_y = nv2y_q;

	a_coin_touch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && centres_coincide |-> touching)
		else $error("coinciding centres reported as not touching");

	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && centres_coincide |-> new_first_vel_x == '0
		&& new_first_vel_y == '0 && new_second_vel_x == '0 && new_second_vel_y == '0)
		else $error("coinciding centres with nonzero velocity");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> v_s1)
		else $error("accepted item missing from first stage");

endmodule
